@@ sv/kc3_pkg.sv @@
// Shared types and constants for the 3x3 convolution filter.
// No dependencies; every module of the block imports this package.

package kc3_pkg;

   // Default line store depth, handed to the top level parameter
   localparam int MAX_WIDTH_DEF = 2048;

   // Field widths
   localparam int PIX_W       = 8;
   localparam int KSEL_W      = 3;
   localparam int IMG_W_W     = 12;
   localparam int IMG_H_W     = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_ADDR_W  = 2;
   localparam int COL_OUT_W   = 11;
   localparam int ROW_W       = 16;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 40;
   localparam int RSP_PAD_W   = RSP_DATA_W - PIX_W - COL_OUT_W - ROW_W;

   // Pre-sum width: holds 0..4080 and -2040..2295 as two's complement
   localparam int ACC_W       = 13;

   // Geometry limits and reset values
   localparam int MIN_DIM     = 3;
   localparam int IMG_W_RESET = 640;
   localparam int IMG_H_RESET = 480;

   // Box: floor(S * 11111 / 100000) == (S * BOX_MUL) >> BOX_SHIFT for S <= 2295
   localparam int             BOX_IN_W   = 12;
   localparam int             BOX_MUL_W  = 25;
   localparam int             BOX_PROD_W = BOX_IN_W + BOX_MUL_W;
   localparam int             BOX_SHIFT  = 28;
   localparam logic [BOX_MUL_W-1:0] BOX_MUL = 25'd29825864;

   // Divide by three: x / 3 == (x * 683) >> 11 for x <= 765
   localparam int             DIV3_IN_W   = 10;
   localparam int             DIV3_MUL_W  = 11;
   localparam int             DIV3_PROD_W = DIV3_IN_W + DIV3_MUL_W;
   localparam int             DIV3_SHIFT  = 11;
   localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 11'd683;

   // Configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_KERNEL = 2'd0,
      CSR_WIDTH  = 2'd1,
      CSR_HEIGHT = 2'd2
   } csr_index_type;

   // Kernel codes
   typedef enum logic [KSEL_W-1:0] {
      K_BOX       = 3'd0,
      K_GAUSS     = 3'd1,
      K_PREWITT_X = 3'd2,
      K_PREWITT_Y = 3'd3,
      K_SOBEL_X   = 3'd4,
      K_SOBEL_Y   = 3'd5,
      K_LAPLACE   = 3'd6,
      K_SHARPEN   = 3'd7
   } kernel_type;

   // Position tag that travels with a result
   typedef struct packed {
      logic [ROW_W-1:0]     row;
      logic [COL_OUT_W-1:0] col;
      logic                 last;
   } pos_type;

endpackage

@@ sv/kc3_line_buf.sv @@
// Line store RAM: upper and middle line packed into one 16-bit word per column.
// One read and one write per cycle, registered read, write-to-read forwarding.
// Depends on kc3_pkg.

module kc3_line_buf import kc3_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
   input  logic [2*PIX_W-1:0]            wr_data,
   output logic [2*PIX_W-1:0]            rd_data
);

   logic [2*PIX_W-1:0] mem_ff [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_ff;
   logic [2*PIX_W-1:0] fwd_data_ff;
   logic               fwd_ff;

   // RAM: write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff       <= mem_ff[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   // Read and write to the same column in one cycle: RAM returns old data
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_ff;

endmodule

@@ sv/kc3_window.sv @@
// 3x3 window registers and the kernel pre-sum stage.
// Shifts one column per pixel and registers the selected weighted sum.
// Depends on kc3_pkg.

module kc3_window import kc3_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  logic              load_en,
   input  logic [PIX_W-1:0]  up_px,
   input  logic [PIX_W-1:0]  mid_px,
   input  logic [PIX_W-1:0]  low_px,
   input  kernel_type        ksel,
   input  pos_type           pos_in,
   output logic [ACC_W-1:0]  acc_ff,
   output kernel_type        ksel_ff,
   output pos_type           pos_ff
);

   logic [PIX_W-1:0] win_ff [9];
   logic [PIX_W-1:0] win_in [9];
   logic [ACC_W-1:0] ex [9];
   logic [ACC_W-1:0] ring;
   logic [ACC_W-1:0] acc_in;

   // Window after this pixel's shift; new column enters on the right
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k*3]     = win_ff[k*3+1];
         win_in[k*3+1]   = win_ff[k*3+2];
      end
      win_in[2] = up_px;
      win_in[5] = mid_px;
      win_in[8] = low_px;
      for (int k = 0; k < 9; k++) begin
         ex[k] = ACC_W'(win_in[k]);
      end
   end

   // Kernel pre-sum, two's complement in ACC_W bits
   always_comb begin
      ring = ex[0] + ex[1] + ex[2] + ex[3] + ex[5] + ex[6] + ex[7] + ex[8];
      case (ksel)
         K_BOX:       acc_in = ring + ex[4];
         K_GAUSS:     acc_in = ex[0] + (ex[1] << 1) + ex[2] + (ex[3] << 1) + (ex[4] << 2)
                               + (ex[5] << 1) + ex[6] + (ex[7] << 1) + ex[8];
         K_PREWITT_X: acc_in = (ex[2] + ex[5] + ex[8]) - (ex[0] + ex[3] + ex[6]);
         K_PREWITT_Y: acc_in = (ex[6] + ex[7] + ex[8]) - (ex[0] + ex[1] + ex[2]);
         K_SOBEL_X:   acc_in = (ex[2] + (ex[5] << 1) + ex[8]) - (ex[0] + (ex[3] << 1) + ex[6]);
         K_SOBEL_Y:   acc_in = (ex[6] + (ex[7] << 1) + ex[8]) - (ex[0] + (ex[1] << 1) + ex[2]);
         K_LAPLACE:   acc_in = (ex[4] << 3) - ring;
         default:     acc_in = (ex[4] << 3) + ex[4] - ring;
      endcase
   end

   // Window state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else if (shift_en) begin
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   // Pre-sum stage register
   always_ff @(posedge clock) begin
      if (load_en) begin
         acc_ff  <= acc_in;
         ksel_ff <= ksel;
         pos_ff  <= pos_in;
      end
   end

endmodule

@@ sv/kc3_post.sv @@
// Post-scaling stage: magnitude, constant divide, clamp, output register.
// Depends on kc3_pkg.

module kc3_post import kc3_pkg::*; (
   input  logic              clock,
   input  logic              load_en,
   input  logic [ACC_W-1:0]  acc,
   input  kernel_type        ksel,
   input  pos_type           pos_in,
   output logic [PIX_W-1:0]  filtered_ff,
   output pos_type           pos_ff
);

   logic                   neg;
   logic [ACC_W-1:0]       mag;
   logic [BOX_PROD_W-1:0]  box_prod;
   logic [DIV3_PROD_W-1:0] div3_prod;
   logic [PIX_W-1:0]       filtered_in;

   // Magnitude and the two constant multiplies
   always_comb begin
      neg       = acc[ACC_W-1];
      mag       = neg ? (~acc + 1'b1) : acc;
      box_prod  = BOX_PROD_W'(acc[BOX_IN_W-1:0]) * BOX_PROD_W'(BOX_MUL);
      div3_prod = DIV3_PROD_W'(mag[DIV3_IN_W-1:0]) * DIV3_PROD_W'(DIV3_MUL);
   end

   // Per-kernel scaling
   always_comb begin
      case (ksel)
         K_BOX:       filtered_in = box_prod[BOX_SHIFT +: PIX_W];
         K_GAUSS:     filtered_in = acc[4 +: PIX_W];
         K_PREWITT_X,
         K_PREWITT_Y: filtered_in = div3_prod[DIV3_SHIFT +: PIX_W];
         K_SOBEL_X,
         K_SOBEL_Y:   filtered_in = mag[2 +: PIX_W];
         K_LAPLACE:   filtered_in = mag[3 +: PIX_W];
         default: begin
            // sharpen: clamp to pixel range
            if (neg) begin
               filtered_in = '0;
            end else if (|acc[ACC_W-2:PIX_W]) begin
               filtered_in = '1;
            end else begin
               filtered_in = acc[PIX_W-1:0];
            end
         end
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (load_en) begin
         filtered_ff <= filtered_in;
         pos_ff      <= pos_in;
      end
   end

endmodule

@@ sv/kernel_conv3x3_filter.sv @@
// Top level of the 3x3 convolution filter: configuration, raster counters, flow control.
// Depends on kc3_pkg, kc3_line_buf, kc3_window and kc3_post.
//
//   channel   direction  transaction             fields
//   req_      in         one pixel               tdata: pixel; tuser: frame_start
//   rsp_      out        one filtered pixel      tdata: filtered, centre_col, centre_row; tlast
//   csr_      in         one register write      csr_addr: index; csr_wdata: value
//
// One pixel per clock sustained while rsp_ does not stall. After its pixel is accepted, a
// result passes line store read, pre-sum and scaling before it leaves the output register.
// The line store RAM does one read and one write per cycle, which sets that rate.
// Reset clears counters, window and valid flags; the line stores are not cleared.
// A stall on rsp_ backs up through three stages before req_tready drops.

module kernel_conv3x3_filter import kc3_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] pixel
   input  logic                  req_tuser,   // [0] frame_start
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] filtered, [18:8] centre_col,
                                              // [34:19] centre_row, [39:35] zero
   output logic                  rsp_tlast,   // frame_last
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = ($clog2(MAX_WIDTH + 1) > IMG_W_W) ? $clog2(MAX_WIDTH + 1) : IMG_W_W;

   // Configuration
   kernel_type           ksel_ff;
   logic [IMG_W_W-1:0]   width_ff;
   logic [IMG_H_W-1:0]   height_ff;

   // Raster counters
   logic [CW-1:0]        col_ff;
   logic [ROW_W-1:0]     row_ff;
   logic [CW-1:0]        col_in;
   logic [ROW_W-1:0]     row_in;
   logic [CW-1:0]        cur_col;
   logic [ROW_W-1:0]     cur_row;
   logic [WW-1:0]        wd_raw;
   logic [WW-1:0]        eff_w;
   logic [IMG_H_W-1:0]   eff_h;
   logic                 end_row;
   logic                 end_frame;
   logic                 has_res;
   logic [CW-1:0]        col_m1;
   pos_type              pos_in;

   // Stage 1: pixel waiting for line store data
   logic                 s1_valid_ff;
   logic                 s1_res_ff;
   logic [PIX_W-1:0]     s1_px_ff;
   logic [CW-1:0]        s1_col_ff;
   pos_type              s1_pos_ff;

   // Stage 2 and output
   logic                 s2_valid_ff;
   logic                 rsp_valid_ff;

   // Handshake terms
   logic                 accept;
   logic                 out_free;
   logic                 s2_free;
   logic                 s2_go;
   logic                 s1_go;

   logic [2*PIX_W-1:0]   lb_rd_data;
   logic [ACC_W-1:0]     s2_acc;
   kernel_type           s2_ksel;
   pos_type              s2_pos;
   logic [PIX_W-1:0]     out_filtered;
   pos_type              out_pos;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ksel_ff   <= K_BOX;
         width_ff  <= IMG_W_W'(IMG_W_RESET);
         height_ff <= IMG_H_W'(IMG_H_RESET);
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_KERNEL: ksel_ff   <= kernel_type'(csr_wdata[KSEL_W-1:0]);
            CSR_WIDTH:  width_ff  <= csr_wdata[IMG_W_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[IMG_H_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective geometry
   always_comb begin
      wd_raw = WW'(width_ff);
      if (wd_raw < WW'(MIN_DIM)) begin
         eff_w = WW'(MIN_DIM);
      end else if (wd_raw > WW'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = wd_raw;
      end
      eff_h = (height_ff < IMG_H_W'(MIN_DIM)) ? IMG_H_W'(MIN_DIM) : height_ff;
   end

   // Position of the incoming pixel and counter advance
   always_comb begin
      cur_col   = req_tuser ? '0 : col_ff;
      cur_row   = req_tuser ? '0 : row_ff;
      end_row   = (WW'(cur_col) + WW'(1)) >= eff_w;
      end_frame = end_row && (({1'b0, cur_row} + 17'd1) >= {1'b0, eff_h});
      if (end_row) begin
         col_in = '0;
         row_in = end_frame ? '0 : cur_row + 1'b1;
      end else begin
         col_in = cur_col + 1'b1;
         row_in = cur_row;
      end
      has_res     = (cur_row >= ROW_W'(2)) && (cur_col >= CW'(2));
      col_m1      = cur_col - 1'b1;
      pos_in.col  = COL_OUT_W'(col_m1);
      pos_in.row  = cur_row - 1'b1;
      pos_in.last = end_frame;
   end

   // Flow control: each stage moves when the next one is free; a stage 1 pixel with no result does not wait for stage 2
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      s2_go      = s2_valid_ff && out_free;
      s2_free    = !s2_valid_ff || out_free;
      s1_go      = s1_valid_ff && (!s1_res_ff || s2_free);
      req_tready = !s1_valid_ff || s1_go;
      accept     = req_tvalid && req_tready;
   end

   // Counters
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_go) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_go && s1_res_ff) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_go) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff  <= req_tdata[PIX_W-1:0];
         s1_col_ff <= cur_col;
         s1_res_ff <= has_res;
         s1_pos_ff <= pos_in;
      end
   end

   // Line stores: word holds {upper, middle}; writing {middle, pixel} rolls both lines
   kc3_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data ({lb_rd_data[PIX_W-1:0], s1_px_ff}),
      .rd_data (lb_rd_data)
   );

   kc3_window u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_go),
      .load_en  (s1_go && s1_res_ff),
      .up_px    (lb_rd_data[2*PIX_W-1:PIX_W]),
      .mid_px   (lb_rd_data[PIX_W-1:0]),
      .low_px   (s1_px_ff),
      .ksel     (ksel_ff),
      .pos_in   (s1_pos_ff),
      .acc_ff   (s2_acc),
      .ksel_ff  (s2_ksel),
      .pos_ff   (s2_pos)
   );

   kc3_post u_post (
      .clock       (clock),
      .load_en     (s2_go),
      .acc         (s2_acc),
      .ksel        (s2_ksel),
      .pos_in      (s2_pos),
      .filtered_ff (out_filtered),
      .pos_ff      (out_pos)
   );

   // Result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), out_pos.row, out_pos.col, out_filtered};
   assign rsp_tlast  = out_pos.last;

`ifndef SYNTHESIS
   // Column counter stays inside the row after every pixel
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      ($past(accept) && !$past(csr_we) && !$past(reset)) |-> (WW'(col_ff) < eff_w))
      else $error("column counter beyond row width");

   // A frame start pixel leaves the counter at column one
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      ($past(accept && req_tuser) && !$past(reset)) |-> (col_ff == CW'(1)))
      else $error("frame start did not restart the column count");

   // Results only for interior rows: the centre row is never row zero
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[PIX_W+COL_OUT_W +: ROW_W] != '0))
      else $error("result for a border row");
`endif

endmodule

@@ test/conv3x3_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the 3x3 convolution filter: tracks register writes and accepted pixels,
// predicts every filtered pixel and compares it field by field with the result stream.
// Depends on kc3_pkg for field widths, register indexes and kernel codes.

module conv3x3_checker import kc3_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] pixel
   input  logic                  req_tuser,   // [0] frame_start
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] filtered, [18:8] centre_col,
                                              // [34:19] centre_row, [39:35] zero
   input  logic                  rsp_tlast,   // frame_last
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    outstanding
);

   localparam int LINE_DEPTH = MAX_WIDTH_DEF;

   typedef struct packed {
      logic [PIX_W-1:0]     filtered;
      logic [COL_OUT_W-1:0] col;
      logic [ROW_W-1:0]     row;
      logic                 last;
   } filtered_pixel_type;

   filtered_pixel_type expected_pixels[$];

   // Shadow of the block: two line stores, the 3x3 window, raster position, registers
   logic [PIX_W-1:0]   upper_line [LINE_DEPTH];
   logic [PIX_W-1:0]   middle_line [LINE_DEPTH];
   logic [PIX_W-1:0]   window [9];
   int                 col_pos;
   int                 row_pos;
   kernel_type         kernel;
   logic [IMG_W_W-1:0] width_reg;
   logic [IMG_H_W-1:0] height_reg;

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // Filter value for the current window under the selected kernel
   function automatic logic [PIX_W-1:0] filter_window_value();
      int a, b, c, d, e, f, g, h, i;
      int ring, v;
      a = window[0]; b = window[1]; c = window[2];
      d = window[3]; e = window[4]; f = window[5];
      g = window[6]; h = window[7]; i = window[8];
      ring = a + b + c + d + f + g + h + i;
      case (kernel)
         K_BOX:       v = ((ring + e) * 11111) / 100000;
         K_GAUSS:     v = (a + 2*b + c + 2*d + 4*e + 2*f + g + 2*h + i) / 16;
         K_PREWITT_X: v = magnitude((c + f + i) - (a + d + g)) / 3;
         K_PREWITT_Y: v = magnitude((g + h + i) - (a + b + c)) / 3;
         K_SOBEL_X:   v = magnitude((c + 2*f + i) - (a + 2*d + g)) / 4;
         K_SOBEL_Y:   v = magnitude((g + 2*h + i) - (a + 2*b + c)) / 4;
         K_LAPLACE:   v = magnitude(8*e - ring) / 8;
         default: begin
            // sharpen saturates to the pixel range
            v = 9*e - ring;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
         end
      endcase
      return v[PIX_W-1:0];
   endfunction

   // One accepted pixel: line stores, window shift, raster counters, expected result
   task automatic advance_raster(input logic [PIX_W-1:0] pix, input logic start);
      int                 wd, ht, idx;
      logic [PIX_W-1:0]   up, md;
      bit                 end_row, end_frame;
      filtered_pixel_type res;
      wd = width_reg;
      if (wd < MIN_DIM) wd = MIN_DIM;
      if (wd > LINE_DEPTH) wd = LINE_DEPTH;
      ht = height_reg;
      if (ht < MIN_DIM) ht = MIN_DIM;
      if (start) begin
         col_pos = 0;
         row_pos = 0;
      end
      idx = (col_pos < LINE_DEPTH) ? col_pos : LINE_DEPTH - 1;
      up = upper_line[idx];
      md = middle_line[idx];
      upper_line[idx]  = md;
      middle_line[idx] = pix;
      for (int k = 0; k < 3; k++) begin
         window[k*3]   = window[k*3+1];
         window[k*3+1] = window[k*3+2];
      end
      window[2] = up;
      window[5] = md;
      window[8] = pix;
      end_row   = (col_pos + 1 >= wd);
      end_frame = end_row && (row_pos + 1 >= ht);
      if (row_pos >= 2 && col_pos >= 2) begin
         res.filtered = filter_window_value();
         res.col      = COL_OUT_W'(col_pos - 1);
         res.row      = ROW_W'(row_pos - 1);
         res.last     = end_frame;
         expected_pixels.push_back(res);
      end
      if (end_row) begin
         col_pos = 0;
         row_pos = end_frame ? 0 : ((row_pos + 1) & 16'hFFFF);
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("[%0t] conv3x3 mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // One result transaction against the oldest expectation
   task automatic check_result();
      filtered_pixel_type want;
      logic [PIX_W-1:0]     got_pix;
      logic [COL_OUT_W-1:0] got_col;
      logic [ROW_W-1:0]     got_row;
      got_pix = rsp_tdata[PIX_W-1:0];
      got_col = rsp_tdata[PIX_W +: COL_OUT_W];
      got_row = rsp_tdata[PIX_W+COL_OUT_W +: ROW_W];
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("result with none expected (col %0d row %0d)",
                                   got_col, got_row));
      end else begin
         want = expected_pixels.pop_front();
         if (got_pix !== want.filtered)
            report_mismatch($sformatf("filtered got %0d want %0d at col %0d row %0d",
                                      got_pix, want.filtered, want.col, want.row));
         if (got_col !== want.col)
            report_mismatch($sformatf("centre_col got %0d want %0d", got_col, want.col));
         if (got_row !== want.row)
            report_mismatch($sformatf("centre_row got %0d want %0d", got_row, want.row));
         if (rsp_tlast !== want.last)
            report_mismatch($sformatf("frame_last got %0b want %0b at col %0d row %0d",
                                      rsp_tlast, want.last, want.col, want.row));
         if (rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W] !== '0)
            report_mismatch($sformatf("pad bits not zero: %h",
                                      rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W]));
      end
   endtask

   // Watch all three channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         col_pos    = 0;
         row_pos    = 0;
         kernel     = K_BOX;
         width_reg  = IMG_W_RESET;
         height_reg = IMG_H_RESET;
         for (int k = 0; k < 9; k++) window[k] = '0;
         expected_pixels.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_KERNEL: kernel     = kernel_type'(csr_wdata[KSEL_W-1:0]);
               CSR_WIDTH:  width_reg  = csr_wdata[IMG_W_W-1:0];
               CSR_HEIGHT: height_reg = csr_wdata[IMG_H_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) advance_raster(req_tdata[PIX_W-1:0], req_tuser);
         if (rsp_tvalid && rsp_tready) check_result();
      end
      outstanding <= expected_pixels.size();
   end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top for kernel_conv3x3_filter: clock, reset, pixel frames, register writes,
// result back-pressure and the verdict. Depends on kc3_pkg, the block and conv3x3_checker.

module tb_top;
   import kc3_pkg::*;

   localparam int LONG_HOLD    = 400;   // cycles the result side stays stalled once
   localparam int RANDOM_ITEMS = 250;
   localparam int WIDE_PIXELS  = 40;    // start of the widest row only
   localparam int SETTLE       = 8;     // pipeline depth plus margin
   localparam int DRAIN        = 20;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // [7:0] pixel
   logic                  req_tuser = 1'b0; // [0] frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [7:0] filtered, [18:8] centre_col,
                                            // [34:19] centre_row, [39:35] zero
   logic                  rsp_tlast;        // frame_last
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatches;
   int outstanding;
   bit quiet_tail    = 1'b0;  // no idling on either side
   bit hold_results  = 1'b0;  // request for one long result stall
   int req_gap_odds  = 3;     // 0: no gaps, n: gap before 1 in n+1 pixels
   int pixels_sent   = 0;

   always #4 clock = ~clock;

   kernel_conv3x3_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   conv3x3_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // One pixel transaction, with an occasional idle burst ahead of it
   task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic start);
      if (!quiet_tail && req_gap_odds != 0 && $urandom_range(0, req_gap_odds) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
   endtask

   // Stop offering and wait until every expected result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Block must be idle: drained, then the pipeline given time to empty
   task automatic program_filter(input kernel_type k, input int w, input int h);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      write_reg(CSR_KERNEL, {13'($urandom), k});
      write_reg(CSR_WIDTH, {4'($urandom), 12'(w)});
      write_reg(CSR_HEIGHT, 16'(h));
   endtask

   // style 0: uniform, 1: black or white only, else mostly uniform with extremes
   function automatic logic [PIX_W-1:0] pick_pixel(input int style);
      int r;
      r = $urandom_range(0, 9);
      if (style == 1) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      if (style != 0 && r == 0) return 8'h00;
      if (style != 0 && r == 1) return 8'hFF;
      return PIX_W'($urandom);
   endfunction

   // Raster pixels; only the first one may carry frame_start
   task automatic send_frame(input int cols, input int rows, input bit start,
                             input int stop_after, input int style);
      for (int n = 0; n < cols * rows && n < stop_after; n++)
         push_pixel(pick_pixel(style), start && n == 0);
   endtask

   // 3x3 frame: centre value surrounded by one ring value
   task automatic send_window(input logic [PIX_W-1:0] centre, input logic [PIX_W-1:0] ring,
                              input bit start);
      for (int n = 0; n < 9; n++)
         push_pixel((n == 4) ? centre : ring, start && n == 0);
   endtask

   // Result side: random stalls, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_results) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_results = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Run limit
   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      int base, w, h, wd, ht, frames, stop, style;
      bit complete, abort;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: width and height below the minimum, box kernel from reset, white frame then black frame
      write_reg(CSR_WIDTH, 16'd2);
      write_reg(CSR_HEIGHT, 16'd0);
      send_window(8'hFF, 8'hFF, 1'b1);
      send_window(8'h00, 8'h00, 1'b1);
      // sharpen clamps both ways; second frame follows without frame_start
      program_filter(K_SHARPEN, 3, 3);
      send_window(8'hFF, 8'h00, 1'b1);
      send_window(8'h00, 8'hFF, 1'b0);

      // Widest line: width register at its top; the start of a row only, then abandoned
      program_filter(kernel_type'($urandom_range(0, 7)), 4095, 3);
      send_frame(MAX_WIDTH_DEF, 3, 1'b1, WIDE_PIXELS, 2);

      // Tallest frame: a few rows only, then abandoned by the next phase
      program_filter(kernel_type'($urandom_range(0, 7)), 3, 65535);
      send_frame(3, 4, 1'b1, 12, 1);

      // Back-pressure: results held off while pixels keep coming, then a sender pause
      program_filter(K_SOBEL_X, 16, 6);
      hold_results = 1'b1;
      send_frame(16, 6, 1'b1, 96, 2);
      send_frame(16, 6, 1'b1, 48, 1);
      wait_drained();
      send_frame(16, 3, 1'b0, 48, 0);

      // Random phases of mostly well-formed frames, some cut short
      base = pixels_sent;
      while (pixels_sent - base < RANDOM_ITEMS) begin
         if (pixels_sent - base > RANDOM_ITEMS * 4 / 5) quiet_tail = 1'b1;
         w = $urandom_range(0, 19);
         if (w < 14) w = $urandom_range(3, 10);
         else if (w < 18) w = $urandom_range(11, 48);
         else w = $urandom_range(0, 2);
         h = ($urandom_range(0, 9) != 0) ? $urandom_range(3, 6) : $urandom_range(0, 2);
         wd = (w < MIN_DIM) ? MIN_DIM : w;
         ht = (h < MIN_DIM) ? MIN_DIM : h;
         program_filter(kernel_type'($urandom_range(0, 7)), w, h);
         req_gap_odds = $urandom_range(0, 3);
         frames   = $urandom_range(1, 3);
         complete = 1'b0;
         for (int f = 0; f < frames; f++) begin
            abort = ($urandom_range(0, 5) == 0);
            stop  = abort ? $urandom_range(1, wd * ht - 1) : wd * ht;
            style = $urandom_range(0, 2);
            send_frame(wd, ht, !complete || $urandom_range(0, 1) != 0, stop, style);
            complete = !abort;
         end
      end

      wait_drained();
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
